// ===== design/sambd_pkg.sv =====
// ----------------------------------------------------------------------------
// sambd_pkg
// Shared types, codes and helpers for the sparse admittance matrix builder.
// ----------------------------------------------------------------------------
package sambd_pkg;

  localparam int NODE_MAX_W = 16;

  localparam logic [1:0] REQ_ADD    = 2'd0;
  localparam logic [1:0] REQ_REMOVE = 2'd1;
  localparam logic [1:0] REQ_READ   = 2'd2;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_ZERO_Z = 2'd2;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [9:0]         node_a;
    logic [9:0]         node_b;
    logic signed [31:0] resistance;
    logic signed [31:0] reactance;
    logic signed [31:0] shunt_susceptance;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic               entry_present;
    logic signed [31:0] conductance_out;
    logic signed [31:0] susceptance_out;
  } out_item_t;

  typedef enum logic [1:0] {CMD_NOP, CMD_READ, CMD_LINE} cmd_kind_t;

  typedef struct packed {
    cmd_kind_t               kind;
    logic                    sub;
    logic [NODE_MAX_W-1:0]   node_lo;
    logic [NODE_MAX_W-1:0]   node_hi;
    logic signed [31:0]      res;
    logic signed [31:0]      rea;
    logic signed [31:0]      shunt;
  } cmd_t;

  typedef struct packed {
    logic                  lookup;
    logic                  sub;
    logic [NODE_MAX_W-1:0] row;
    logic [NODE_MAX_W-1:0] col;
    logic signed [31:0]    dre;
    logic signed [31:0]    dim;
  } tbl_req_t;

  typedef struct packed {
    logic               busy;
    logic               done;
    logic               full;
    logic               hit;
    logic signed [31:0] re;
    logic signed [31:0] im;
  } tbl_rsp_t;

  typedef enum logic [2:0] {RC_IDLE, RC_SQ, RC_SUM, RC_DIV, RC_DONE} recip_state_t;
  typedef enum logic [1:0] {T_CLEAR, T_IDLE, T_SCAN, T_WRITE} tbl_state_t;
  typedef enum logic [2:0] {
    B_IDLE, B_RECIP, B_UPD1, B_UPD2, B_UPD3, B_LOOK, B_OUT
  } back_state_t;

  function automatic logic signed [31:0] sat32(input logic signed [32:0] v);
    logic signed [31:0] r;
    if (v[32] != v[31]) begin
      r = v[32] ? {1'b1, {31{1'b0}}} : {1'b0, {31{1'b1}}};
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// ===== design/sparse_admittance_matrix_builder_core.sv =====
// ----------------------------------------------------------------------------
// sparse_admittance_matrix_builder_core
// Sparse bus admittance matrix builder: line add/remove and entry read.
// ----------------------------------------------------------------------------
// Read: one linear scan of the slot table.
// Line: two 64-step divisions, then three scans through the table's one read port.
// One request executes at a time; a two-deep command queue takes new ones.
// Reset: a clearing pass writes every slot; full stays high meanwhile.
module sparse_admittance_matrix_builder_core #(
  parameter int TABLE_ENTRIES = 256,
  parameter int NODE_BITS     = 10
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  output logic                 full,
  input  sambd_pkg::in_item_t  in_item,
  input  logic                 pop,
  output logic                 empty,
  output sambd_pkg::out_item_t out_item
);

  logic            clearing;
  logic            cmd_valid;
  logic            cmd_pop;
  sambd_pkg::cmd_t cmd_head;

  sambd_front #(
    .NODE_BITS (NODE_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .in_item   (in_item),
    .clearing  (clearing),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop),
    .cmd_head  (cmd_head)
  );

  sambd_back #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .NODE_BITS     (NODE_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_head  (cmd_head),
    .cmd_pop   (cmd_pop),
    .clearing  (clearing),
    .pop       (pop),
    .empty     (empty),
    .out_item  (out_item)
  );

  a_clear_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> full)
    else $error("input open during clearing pass");

  a_present_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_item.entry_present) |-> (out_item.status == sambd_pkg::ST_OK))
    else $error("present entry with nonzero status");

  a_zero_z_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_item.status == sambd_pkg::ST_ZERO_Z) |->
      (out_item.conductance_out == '0 && out_item.susceptance_out == '0))
    else $error("zero impedance result carries data");

  a_no_pop_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> !cmd_pop)
    else $error("command taken during clearing pass");

endmodule

// ===== design/sambd_front.sv =====
// ----------------------------------------------------------------------------
// sambd_front
// Takes requests, orders the node pair, classifies them and queues commands.
// ----------------------------------------------------------------------------
module sambd_front #(
  parameter int NODE_BITS = 10
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  output logic                full,
  input  sambd_pkg::in_item_t in_item,
  input  logic                clearing,
  output logic                cmd_valid,
  input  logic                cmd_pop,
  output sambd_pkg::cmd_t     cmd_head
);

  sambd_pkg::cmd_t             q_r [2];
  logic                        wr_ptr_r, wr_ptr_nxt;
  logic                        rd_ptr_r, rd_ptr_nxt;
  logic [1:0]                  cnt_r, cnt_nxt;
  logic                        accept;
  logic                        take;
  sambd_pkg::cmd_t             cls;
  logic [sambd_pkg::NODE_MAX_W-1:0] a_ext, b_ext;
  logic [NODE_BITS-1:0]        na, nb, lo, hi;

  always_comb begin
    a_ext = '0;
    b_ext = '0;
    a_ext[9:0] = in_item.node_a;
    b_ext[9:0] = in_item.node_b;
    na = a_ext[NODE_BITS-1:0];
    nb = b_ext[NODE_BITS-1:0];
    lo = (na > nb) ? nb : na;
    hi = (na > nb) ? na : nb;
    cls = '0;
    cls.node_lo[NODE_BITS-1:0] = lo;
    cls.node_hi[NODE_BITS-1:0] = hi;
    cls.res   = in_item.resistance;
    cls.rea   = in_item.reactance;
    cls.shunt = in_item.shunt_susceptance;
    cls.sub   = (in_item.req_type == sambd_pkg::REQ_REMOVE);
    if (lo == '0) begin
      cls.kind = sambd_pkg::CMD_NOP;
    end else begin
      case (in_item.req_type)
        sambd_pkg::REQ_READ:   cls.kind = sambd_pkg::CMD_READ;
        sambd_pkg::REQ_ADD:    cls.kind = sambd_pkg::CMD_LINE;
        sambd_pkg::REQ_REMOVE: cls.kind = sambd_pkg::CMD_LINE;
        default:               cls.kind = sambd_pkg::CMD_NOP;
      endcase
    end
  end

  assign full      = (cnt_r == 2'd2) || clearing;
  assign accept    = push && !full;
  assign cmd_valid = (cnt_r != 2'd0);
  assign take      = cmd_pop && cmd_valid;
  assign cmd_head  = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = accept ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = take ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, accept} - {1'b0, take};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      q_r[wr_ptr_r] <= cls;
    end
  end

endmodule

// ===== design/sambd_recip.sv =====
// ----------------------------------------------------------------------------
// sambd_recip
// Complex reciprocal 1/(R+jX) by squaring and a shared bit-serial divider.
// ----------------------------------------------------------------------------
module sambd_recip (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [31:0] res,
  input  logic signed [31:0] rea,
  output logic               done,
  output logic               zero_imp,
  output logic signed [31:0] g,
  output logic signed [31:0] bs
);

  localparam int DIV_STEPS = 64;
  localparam int STEP_W = $clog2(DIV_STEPS);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DIV_STEPS - 1);
  localparam logic [63:0] POS_LIM = 64'h0000_0000_7FFF_FFFF;

  sambd_pkg::recip_state_t state_r, state_nxt;
  logic [31:0]        ar_r, ar_nxt, ax_r, ax_nxt;
  logic               rneg_r, rneg_nxt, xpos_r, xpos_nxt;
  logic [63:0]        sqa_r, sqa_nxt, sqx_r, sqx_nxt;
  logic [63:0]        d_r, d_nxt;
  logic [64:0]        rem_r, rem_nxt;
  logic [63:0]        quo_r, quo_nxt;
  logic [STEP_W-1:0]  step_r, step_nxt;
  logic               part_r, part_nxt;
  logic               zero_r, zero_nxt;
  logic signed [31:0] g_r, g_nxt, bs_r, bs_nxt;
  logic [63:0]        sum;
  logic [64:0]        t;
  logic               ge;

  function automatic logic signed [31:0] sat_q(input logic [63:0] q, input logic neg);
    logic signed [31:0] r;
    if (!neg) begin
      r = (q > POS_LIM) ? {1'b0, {31{1'b1}}} : q[31:0];
    end else begin
      r = (q > POS_LIM) ? {1'b1, {31{1'b0}}} : (~q[31:0] + 32'd1);
    end
    return r;
  endfunction

  always_comb begin
    state_nxt = state_r;
    ar_nxt = ar_r;
    ax_nxt = ax_r;
    rneg_nxt = rneg_r;
    xpos_nxt = xpos_r;
    sqa_nxt = sqa_r;
    sqx_nxt = sqx_r;
    d_nxt = d_r;
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    step_nxt = step_r;
    part_nxt = part_r;
    zero_nxt = zero_r;
    g_nxt = g_r;
    bs_nxt = bs_r;
    sum = sqa_r + sqx_r;
    t = {rem_r[63:0], quo_r[63]};
    ge = (t >= {1'b0, d_r});
    case (state_r)
      sambd_pkg::RC_IDLE: begin
        if (start) begin
          ar_nxt = res[31] ? (~res + 32'd1) : res;
          ax_nxt = rea[31] ? (~rea + 32'd1) : rea;
          rneg_nxt = res[31];
          xpos_nxt = !rea[31];
          zero_nxt = 1'b0;
          state_nxt = sambd_pkg::RC_SQ;
        end
      end
      sambd_pkg::RC_SQ: begin
        sqa_nxt = ar_r * ar_r;
        sqx_nxt = ax_r * ax_r;
        state_nxt = sambd_pkg::RC_SUM;
      end
      sambd_pkg::RC_SUM: begin
        d_nxt = sum;
        if (sum == '0) begin
          zero_nxt = 1'b1;
          state_nxt = sambd_pkg::RC_DONE;
        end else begin
          rem_nxt = '0;
          quo_nxt = {ar_r, 32'd0} + (sum >> 1);
          step_nxt = '0;
          part_nxt = 1'b0;
          state_nxt = sambd_pkg::RC_DIV;
        end
      end
      sambd_pkg::RC_DIV: begin
        rem_nxt = ge ? (t - {1'b0, d_r}) : t;
        quo_nxt = {quo_r[62:0], ge};
        step_nxt = step_r + 1'b1;
        if (step_r == LAST_STEP) begin
          if (!part_r) begin
            g_nxt = sat_q(quo_nxt, rneg_r);
            rem_nxt = '0;
            quo_nxt = {ax_r, 32'd0} + (d_r >> 1);
            step_nxt = '0;
            part_nxt = 1'b1;
          end else begin
            bs_nxt = sat_q(quo_nxt, xpos_r);
            state_nxt = sambd_pkg::RC_DONE;
          end
        end
      end
      sambd_pkg::RC_DONE: begin
        state_nxt = sambd_pkg::RC_IDLE;
      end
      default: begin
        state_nxt = sambd_pkg::RC_IDLE;
      end
    endcase
  end

  always_comb begin
    done     = (state_r == sambd_pkg::RC_DONE);
    zero_imp = zero_r;
    g        = g_r;
    bs       = bs_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sambd_pkg::RC_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ar_r   <= ar_nxt;
    ax_r   <= ax_nxt;
    rneg_r <= rneg_nxt;
    xpos_r <= xpos_nxt;
    sqa_r  <= sqa_nxt;
    sqx_r  <= sqx_nxt;
    d_r    <= d_nxt;
    rem_r  <= rem_nxt;
    quo_r  <= quo_nxt;
    step_r <= step_nxt;
    part_r <= part_nxt;
    zero_r <= zero_nxt;
    g_r    <= g_nxt;
    bs_r   <= bs_nxt;
  end

endmodule

// ===== design/sambd_table.sv =====
// ----------------------------------------------------------------------------
// sambd_table
// Slot table keyed by node pair: linear search, update, free and lookup.
// ----------------------------------------------------------------------------
module sambd_table #(
  parameter int TABLE_ENTRIES = 256,
  parameter int NODE_BITS     = 10
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  sambd_pkg::tbl_req_t req,
  output sambd_pkg::tbl_rsp_t rsp
);

  localparam int IDX_W   = $clog2(TABLE_ENTRIES);
  localparam int KEY_W   = 2 * NODE_BITS;
  localparam int ENTRY_W = KEY_W + 64;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);
  localparam logic [IDX_W:0]   END_CNT  = (IDX_W + 1)'(TABLE_ENTRIES);

  logic [ENTRY_W-1:0] mem [TABLE_ENTRIES];

  sambd_pkg::tbl_state_t state_r, state_nxt;
  sambd_pkg::tbl_req_t   req_r, req_nxt;
  logic [IDX_W:0]        idx_r, idx_nxt;
  logic                  chk_vld_r, chk_vld_nxt;
  logic [IDX_W-1:0]      chk_idx_r;
  logic [ENTRY_W-1:0]    rd_data_r;
  logic                  hit_r, hit_nxt, free_r, free_nxt;
  logic [IDX_W-1:0]      hit_idx_r, hit_idx_nxt, free_idx_r, free_idx_nxt;
  logic signed [31:0]    old_re_r, old_re_nxt, old_im_r, old_im_nxt;

  logic [IDX_W-1:0]      raddr;
  logic                  issue;
  logic [KEY_W-1:0]      want_key, chk_key;
  logic                  is_free, match;
  logic signed [31:0]    ore, oim, nre, nim;
  logic                  nzero;
  logic                  we;
  logic [IDX_W-1:0]      waddr;
  logic [ENTRY_W-1:0]    wdata;

  always_comb begin
    raddr    = idx_r[IDX_W-1:0];
    issue    = (idx_r != END_CNT);
    want_key = {req_r.row[NODE_BITS-1:0], req_r.col[NODE_BITS-1:0]};
    chk_key  = rd_data_r[ENTRY_W-1 -: KEY_W];
    is_free  = (chk_key == '0);
    match    = !is_free && (chk_key == want_key);
    ore = hit_r ? old_re_r : '0;
    oim = hit_r ? old_im_r : '0;
    if (req_r.sub) begin
      nre = sambd_pkg::sat32({ore[31], ore} - {req_r.dre[31], req_r.dre});
      nim = sambd_pkg::sat32({oim[31], oim} - {req_r.dim[31], req_r.dim});
    end else begin
      nre = sambd_pkg::sat32({ore[31], ore} + {req_r.dre[31], req_r.dre});
      nim = sambd_pkg::sat32({oim[31], oim} + {req_r.dim[31], req_r.dim});
    end
    nzero = (nre == '0) && (nim == '0);
  end

  always_comb begin
    state_nxt = state_r;
    req_nxt = req_r;
    idx_nxt = idx_r;
    chk_vld_nxt = 1'b0;
    hit_nxt = hit_r;
    hit_idx_nxt = hit_idx_r;
    free_nxt = free_r;
    free_idx_nxt = free_idx_r;
    old_re_nxt = old_re_r;
    old_im_nxt = old_im_r;
    case (state_r)
      sambd_pkg::T_CLEAR: begin
        idx_nxt = idx_r + 1'b1;
        if (idx_r[IDX_W-1:0] == LAST_IDX) begin
          state_nxt = sambd_pkg::T_IDLE;
        end
      end
      sambd_pkg::T_IDLE: begin
        if (start) begin
          req_nxt = req;
          idx_nxt = '0;
          hit_nxt = 1'b0;
          free_nxt = 1'b0;
          state_nxt = sambd_pkg::T_SCAN;
        end
      end
      sambd_pkg::T_SCAN: begin
        if (issue) begin
          idx_nxt = idx_r + 1'b1;
        end
        if (chk_vld_r) begin
          if (is_free && !free_r) begin
            free_nxt = 1'b1;
            free_idx_nxt = chk_idx_r;
          end
          if (match) begin
            hit_nxt = 1'b1;
            hit_idx_nxt = chk_idx_r;
            old_re_nxt = rd_data_r[63:32];
            old_im_nxt = rd_data_r[31:0];
            state_nxt = sambd_pkg::T_WRITE;
          end else if (chk_idx_r == LAST_IDX) begin
            state_nxt = sambd_pkg::T_WRITE;
          end
        end
        chk_vld_nxt = issue && (state_nxt == sambd_pkg::T_SCAN);
      end
      sambd_pkg::T_WRITE: begin
        state_nxt = sambd_pkg::T_IDLE;
      end
      default: begin
        state_nxt = sambd_pkg::T_IDLE;
      end
    endcase
  end

  always_comb begin
    we = 1'b0;
    waddr = hit_idx_r;
    wdata = {want_key, nre, nim};
    rsp = '0;
    rsp.busy = (state_r == sambd_pkg::T_CLEAR);
    case (state_r)
      sambd_pkg::T_CLEAR: begin
        we = 1'b1;
        waddr = idx_r[IDX_W-1:0];
        wdata = '0;
      end
      sambd_pkg::T_WRITE: begin
        rsp.done = 1'b1;
        if (req_r.lookup) begin
          rsp.hit = hit_r;
          rsp.re = ore;
          rsp.im = oim;
        end else if (hit_r) begin
          we = 1'b1;
          if (nzero) begin
            wdata[ENTRY_W-1 -: KEY_W] = '0;
          end
        end else if (!free_r) begin
          rsp.full = 1'b1;
        end else if (!nzero) begin
          we = 1'b1;
          waddr = free_idx_r;
        end
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= sambd_pkg::T_CLEAR;
      idx_r     <= '0;
      chk_vld_r <= 1'b0;
      hit_r     <= 1'b0;
      free_r    <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      idx_r     <= idx_nxt;
      chk_vld_r <= chk_vld_nxt;
      hit_r     <= hit_nxt;
      free_r    <= free_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    chk_idx_r  <= raddr;
    hit_idx_r  <= hit_idx_nxt;
    free_idx_r <= free_idx_nxt;
    old_re_r   <= old_re_nxt;
    old_im_r   <= old_im_nxt;
  end

endmodule

// ===== design/sambd_back.sv =====
// ----------------------------------------------------------------------------
// sambd_back
// Executes queued commands: reciprocal, three entry updates or one lookup.
// ----------------------------------------------------------------------------
module sambd_back #(
  parameter int TABLE_ENTRIES = 256,
  parameter int NODE_BITS     = 10
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cmd_valid,
  input  sambd_pkg::cmd_t      cmd_head,
  output logic                 cmd_pop,
  output logic                 clearing,
  input  logic                 pop,
  output logic                 empty,
  output sambd_pkg::out_item_t out_item
);

  sambd_pkg::back_state_t state_r, state_nxt;
  sambd_pkg::cmd_t        cmd_r, cmd_nxt;
  sambd_pkg::out_item_t   res_r, res_nxt, out_r, out_nxt;
  logic                   out_vld_r, out_vld_nxt;
  logic                   issued_r, issued_nxt;
  logic                   full_acc_r, full_acc_nxt;
  logic signed [31:0]     g_r, g_nxt, dim_r, dim_nxt, og_r, og_nxt, ob_r, ob_nxt;
  logic                   recip_start, recip_done, recip_zero;
  logic signed [31:0]     recip_g, recip_bs, half_sh;
  logic                   tbl_start, tbl_state;
  logic                   out_load;
  sambd_pkg::tbl_req_t    tbl_req;
  sambd_pkg::tbl_rsp_t    tbl_rsp;

  sambd_recip u_recip (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (recip_start),
    .res      (cmd_head.res),
    .rea      (cmd_head.rea),
    .done     (recip_done),
    .zero_imp (recip_zero),
    .g        (recip_g),
    .bs       (recip_bs)
  );

  sambd_table #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .NODE_BITS     (NODE_BITS)
  ) u_table (
    .clk   (clk),
    .rst_n (rst_n),
    .start (tbl_start),
    .req   (tbl_req),
    .rsp   (tbl_rsp)
  );

  assign clearing = tbl_rsp.busy;
  assign half_sh  = cmd_r.shunt >>> 1;

  always_comb begin
    tbl_req = '0;
    tbl_req.sub = cmd_r.sub;
    tbl_req.row = cmd_r.node_lo;
    tbl_req.col = cmd_r.node_lo;
    tbl_req.dre = g_r;
    tbl_req.dim = dim_r;
    tbl_state = 1'b1;
    case (state_r)
      sambd_pkg::B_LOOK: begin
        tbl_req.lookup = 1'b1;
        tbl_req.col = cmd_r.node_hi;
      end
      sambd_pkg::B_UPD1: begin
        tbl_req.lookup = 1'b0;
      end
      sambd_pkg::B_UPD2: begin
        tbl_req.row = cmd_r.node_hi;
        tbl_req.col = cmd_r.node_hi;
      end
      sambd_pkg::B_UPD3: begin
        if (cmd_r.node_lo != cmd_r.node_hi) begin
          tbl_req.col = cmd_r.node_hi;
          tbl_req.dre = og_r;
          tbl_req.dim = ob_r;
        end
      end
      default: begin
        tbl_state = 1'b0;
      end
    endcase
    tbl_start = tbl_state && !issued_r;
  end

  always_comb begin
    state_nxt = state_r;
    cmd_nxt = cmd_r;
    res_nxt = res_r;
    full_acc_nxt = full_acc_r;
    g_nxt = g_r;
    dim_nxt = dim_r;
    og_nxt = og_r;
    ob_nxt = ob_r;
    cmd_pop = 1'b0;
    recip_start = 1'b0;
    out_load = 1'b0;
    case (state_r)
      sambd_pkg::B_IDLE: begin
        if (cmd_valid && !tbl_rsp.busy) begin
          cmd_pop = 1'b1;
          cmd_nxt = cmd_head;
          full_acc_nxt = 1'b0;
          res_nxt = '0;
          case (cmd_head.kind)
            sambd_pkg::CMD_READ: begin
              state_nxt = sambd_pkg::B_LOOK;
            end
            sambd_pkg::CMD_LINE: begin
              recip_start = 1'b1;
              state_nxt = sambd_pkg::B_RECIP;
            end
            default: begin
              state_nxt = sambd_pkg::B_OUT;
            end
          endcase
        end
      end
      sambd_pkg::B_RECIP: begin
        if (recip_done) begin
          if (recip_zero) begin
            res_nxt.status = sambd_pkg::ST_ZERO_Z;
            state_nxt = sambd_pkg::B_OUT;
          end else begin
            g_nxt = recip_g;
            dim_nxt = sambd_pkg::sat32({recip_bs[31], recip_bs} + {half_sh[31], half_sh});
            og_nxt = sambd_pkg::sat32(33'sd0 - {recip_g[31], recip_g});
            ob_nxt = sambd_pkg::sat32(33'sd0 - {recip_bs[31], recip_bs});
            state_nxt = sambd_pkg::B_UPD1;
          end
        end
      end
      sambd_pkg::B_UPD1: begin
        if (issued_r && tbl_rsp.done) begin
          full_acc_nxt = full_acc_r | tbl_rsp.full;
          state_nxt = sambd_pkg::B_UPD2;
        end
      end
      sambd_pkg::B_UPD2: begin
        if (issued_r && tbl_rsp.done) begin
          full_acc_nxt = full_acc_r | tbl_rsp.full;
          state_nxt = sambd_pkg::B_UPD3;
        end
      end
      sambd_pkg::B_UPD3: begin
        if (issued_r && tbl_rsp.done) begin
          res_nxt.status = (full_acc_r || tbl_rsp.full) ? sambd_pkg::ST_FULL
                                                        : sambd_pkg::ST_OK;
          state_nxt = sambd_pkg::B_OUT;
        end
      end
      sambd_pkg::B_LOOK: begin
        if (issued_r && tbl_rsp.done) begin
          res_nxt.entry_present = tbl_rsp.hit;
          res_nxt.conductance_out = tbl_rsp.re;
          res_nxt.susceptance_out = tbl_rsp.im;
          state_nxt = sambd_pkg::B_OUT;
        end
      end
      sambd_pkg::B_OUT: begin
        if (!out_vld_r || pop) begin
          out_load = 1'b1;
          state_nxt = sambd_pkg::B_IDLE;
        end
      end
      default: begin
        state_nxt = sambd_pkg::B_IDLE;
      end
    endcase
  end

  always_comb begin
    issued_nxt = issued_r;
    if (tbl_start) begin
      issued_nxt = 1'b1;
    end else if (tbl_rsp.done) begin
      issued_nxt = 1'b0;
    end
    out_nxt = out_load ? res_r : out_r;
    out_vld_nxt = out_vld_r;
    if (out_load) begin
      out_vld_nxt = 1'b1;
    end else if (pop && out_vld_r) begin
      out_vld_nxt = 1'b0;
    end
  end

  assign empty    = !out_vld_r;
  assign out_item = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= sambd_pkg::B_IDLE;
      out_vld_r <= 1'b0;
      issued_r  <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      out_vld_r <= out_vld_nxt;
      issued_r  <= issued_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    res_r      <= res_nxt;
    out_r      <= out_nxt;
    full_acc_r <= full_acc_nxt;
    g_r        <= g_nxt;
    dim_r      <= dim_nxt;
    og_r       <= og_nxt;
    ob_r       <= ob_nxt;
  end

endmodule
